// File: src/rsib_pkg.sv
// rsib_pkg.sv: shared types, constants and helper functions for the rank/select index builder
`timescale 1ns / 1ps
`default_nettype none

package rsib_pkg;

    // fixed word geometry
    localparam int WORD_BITS     = 64;
    localparam int BIT_COUNT_W   = 7;
    localparam int S_TDATA_W     = 72;

    // directory entry geometry
    localparam int IDX_W         = 27;
    localparam int SUB_CNT_W     = 11;
    localparam int N_CUM         = 5;
    localparam int OUT_W         = 33;
    localparam int REL_W         = N_CUM * SUB_CNT_W;
    localparam int M_TDATA_W     = 128;
    localparam int M_TDATA_USED  = 2 * OUT_W + REL_W;

    // result list sizing
    localparam int MAX_RESULTS   = 7;
    localparam int TRAIL_RESULTS = 4;
    localparam int RCNT_W        = 3;

    // sub-block index of the last sub-block of a block
    localparam logic [2:0] LAST_SUB = 3'd5;

    typedef enum logic [1:0] {
        KIND_RANK  = 2'd0,
        KIND_ONES  = 2'd1,
        KIND_ZEROS = 2'd2,
        KIND_TOTAL = 2'd3
    } kind_t;

    typedef logic [N_CUM-1:0][SUB_CNT_W-1:0] cum_t;

    typedef struct packed {
        kind_t             kind;
        logic [OUT_W-1:0]  slot;
        logic [OUT_W-1:0]  value;
        logic [REL_W-1:0]  rel;
        logic              fin;
    } result_t;

    // number of set bits in a word
    function automatic logic [BIT_COUNT_W-1:0] popcount(input logic [WORD_BITS-1:0] v);
        logic [BIT_COUNT_W-1:0] acc;
        acc = '0;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            acc = acc + BIT_COUNT_W'(v[i]);
        end
        return acc;
    endfunction

    // ones in every bit position below len
    function automatic logic [WORD_BITS-1:0] prefix_mask(input logic [15:0] len);
        logic [WORD_BITS-1:0] m;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            m[i] = (16'(i) < len);
        end
        return m;
    endfunction

    // cumulative sub-block counts, sub-block 0 in the top field
    function automatic logic [REL_W-1:0] pack_rel(input cum_t c);
        logic [REL_W-1:0] r;
        for (int j = 0; j < N_CUM; j++)
        begin
            r[REL_W-1-j*SUB_CNT_W -: SUB_CNT_W] = c[j];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: src/rank_select_index_builder.sv
// rank_select_index_builder.sv: streaming builder of rank and select directory entries
`timescale 1ns / 1ps
`default_nettype none

//  channel   | dir | group   | word contents
//  ----------+-----+---------+--------------------------------------------------
//  vector in | in  | s_axis  | word, bit_count in tdata; last in tlast
//  entry out | out | m_axis  | slot, value, rel_packed in tdata; kind in tuser;
//            |     |         | last_result in tlast
//
// one input word is registered, then processed by combinational popcount and compare
// logic that updates the running counters and loads a list of up to seven results
// a word that yields results holds the next word until the single result list has drained,
// one entry per cycle while m_axis_tready is high; words without results flow at one per
// cycle while the list is empty, and each result leaves from the registered result list
// rst_n clears all counters to an empty vector (sample slots to one) and the result list
// output stalls back up through the result list into the input register

module rank_select_index_builder #(
    parameter int SUB_BLOCK_BITS = 256,
    parameter int SELECT_SAMPLE  = 4096,
    parameter int COUNT_BITS     = 32
) (
    input  wire                              clk,
    input  wire                              rst_n,

    input  wire                              s_axis_tvalid,
    output logic                             s_axis_tready,
    // word [63:0], bit_count [70:64], zero pad [71]
    input  wire [rsib_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    input  wire                              s_axis_tlast,

    output logic                             m_axis_tvalid,
    input  wire                              m_axis_tready,
    // slot [32:0], value [65:33], rel_packed [120:66], zero pad [127:121]
    output logic [rsib_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // kind [1:0]
    output logic [1:0]                       m_axis_tuser,
    output logic                             m_axis_tlast
);

    localparam int CNT_W  = COUNT_BITS + 1;
    localparam int SOFF_W = $clog2(SUB_BLOCK_BITS);
    localparam int STE_W  = $clog2(SUB_BLOCK_BITS + 1);
    localparam int RES_W  = $clog2(SELECT_SAMPLE);
    localparam int WL2    = $clog2(rsib_pkg::WORD_BITS);
    localparam int CW     = rsib_pkg::BIT_COUNT_W;
    localparam int IW     = rsib_pkg::IDX_W;
    localparam int OW     = rsib_pkg::OUT_W;
    localparam int NR     = rsib_pkg::MAX_RESULTS;
    localparam int RCW    = rsib_pkg::RCNT_W;

    // input register
    logic                               in_valid_reg, in_valid_next;
    logic [rsib_pkg::WORD_BITS-1:0]     in_word_reg;
    logic [CW-1:0]                      in_cnt_reg;
    logic                               in_last_reg;

    // running state
    logic [2:0]                         sub_reg, sub_next;
    logic [SOFF_W-1:0]                  sub_off_reg, sub_off_next;
    logic [IW-1:0]                      bi_reg, bi_next;
    logic [CNT_W-1:0]                   obb_reg, obb_next;
    rsib_pkg::cum_t                     cum_reg, cum_next;
    logic [CNT_W-1:0]                   ones_reg, ones_next;
    logic [CNT_W-1:0]                   zeros_reg, zeros_next;
    logic [RES_W-1:0]                   r1_reg, r1_next;
    logic [RES_W-1:0]                   r0_reg, r0_next;
    logic [IW-1:0]                      slot1_reg, slot1_next;
    logic [IW-1:0]                      slot0_reg, slot0_next;

    // result list, head at index 0
    rsib_pkg::result_t                  res_reg [NR];
    rsib_pkg::result_t                  res_next [NR];
    logic [RCW-1:0]                     res_cnt_reg, res_cnt_next;

    // handshake
    logic pop, can_load, proc, s_acc;

    // per-word datapath
    logic [CW-1:0]                      cnt_c, k1, k0, ka, kb, za;
    logic [rsib_pkg::WORD_BITS-1:0]     w;
    logic [STE_W-1:0]                   sub_to_end;
    logic                               sub_cross, blk_cross;
    logic [RES_W:0]                     need1_full, need0_full;
    logic [CW-1:0]                      need1_res, need0_res, dist1, dist0, need1, need0;
    logic                               hit1, hit0, ones_after, zeros_after, ones_first;
    logic [7:0]                         order_len;

    // word-updated state, before the end-of-vector restart
    logic [2:0]                         sub_upd;
    logic [SOFF_W-1:0]                  sub_off_upd;
    logic [IW-1:0]                      bi_upd, slot1_upd, slot0_upd;
    logic [CNT_W-1:0]                   obb_upd, ones_upd, zeros_upd;
    logic [RES_W-1:0]                   r1_upd, r0_upd;
    rsib_pkg::cum_t                     cum_upd;
    logic [IW:0]                        after;

    rsib_pkg::result_t                  e_ones, e_zeros, e_rank;
    rsib_pkg::result_t                  t_rank, t_total, t_s1, t_s0;
    rsib_pkg::result_t                  list [NR];
    logic [RCW-1:0]                     idx_ones, idx_zeros, idx_rank, n_word, n_new;

    // ---------------- handshake ----------------
    assign m_axis_tvalid = (res_cnt_reg != '0);
    assign pop           = m_axis_tvalid && m_axis_tready;
    // the list can take a new word when empty or when its only entry leaves now
    assign can_load      = (res_cnt_reg == '0) ||
                           ((res_cnt_reg == RCW'(1)) && m_axis_tready);
    assign proc          = in_valid_reg && can_load;
    assign s_axis_tready = !in_valid_reg || can_load;
    assign s_acc         = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_acc)
        begin
            in_valid_next = 1'b1;
        end
        else if (proc)
        begin
            in_valid_next = 1'b0;
        end
    end

    // ---------------- word datapath ----------------
    always_comb
    begin
        // oversized counts clamp to a full word
        cnt_c = (in_cnt_reg > CW'(rsib_pkg::WORD_BITS)) ? CW'(rsib_pkg::WORD_BITS)
                                                        : in_cnt_reg;
        w     = in_word_reg & rsib_pkg::prefix_mask(16'(cnt_c));
        k1    = rsib_pkg::popcount(w);
        k0    = cnt_c - k1;

        // bits left in the current sub-block; a word crosses at most one boundary
        sub_to_end = STE_W'(SUB_BLOCK_BITS) - STE_W'(sub_off_reg);
        sub_cross  = (16'(sub_to_end) <= 16'(cnt_c));
        blk_cross  = sub_cross && (sub_reg == rsib_pkg::LAST_SUB);
        ka         = rsib_pkg::popcount(w & rsib_pkg::prefix_mask(16'(sub_to_end)));
        kb         = k1 - ka;
        za         = CW'(sub_to_end) - ka;

        // ones or zeros still needed for the next sample: next multiple or counter wrap
        need1_full = (RES_W+1)'(SELECT_SAMPLE) - {1'b0, r1_reg};
        need0_full = (RES_W+1)'(SELECT_SAMPLE) - {1'b0, r0_reg};
        need1_res  = (need1_full > (RES_W+1)'(rsib_pkg::WORD_BITS))
                     ? CW'(rsib_pkg::WORD_BITS + 1) : CW'(need1_full);
        need0_res  = (need0_full > (RES_W+1)'(rsib_pkg::WORD_BITS))
                     ? CW'(rsib_pkg::WORD_BITS + 1) : CW'(need0_full);
        dist1      = CW'(rsib_pkg::WORD_BITS) - {1'b0, ones_reg[WL2-1:0]};
        dist0      = CW'(rsib_pkg::WORD_BITS) - {1'b0, zeros_reg[WL2-1:0]};
        need1      = ((&ones_reg[CNT_W-1:WL2]) && (dist1 < need1_res)) ? dist1 : need1_res;
        need0      = ((&zeros_reg[CNT_W-1:WL2]) && (dist0 < need0_res)) ? dist0 : need0_res;
        hit1       = (need1 <= k1);
        hit0       = (need0 <= k0);

        // a sample past the block boundary belongs to the next block
        ones_after  = blk_cross && (need1 > ka);
        zeros_after = blk_cross && (need0 > za);

        // within need0 + need1 - 1 bits exactly one of the two samples lands
        order_len  = 8'(need0) + 8'(need1) - 8'd1;
        ones_first = (rsib_pkg::popcount(w & rsib_pkg::prefix_mask(16'(order_len))) >= need1);

        // state after this word's bits
        sub_upd     = blk_cross ? 3'd0 : (sub_cross ? sub_reg + 3'd1 : sub_reg);
        sub_off_upd = sub_cross ? SOFF_W'(16'(cnt_c) - 16'(sub_to_end))
                                : SOFF_W'(16'(sub_off_reg) + 16'(cnt_c));
        bi_upd      = blk_cross ? bi_reg + IW'(1) : bi_reg;
        obb_upd     = blk_cross ? ones_reg + CNT_W'(ka) : obb_reg;
        ones_upd    = ones_reg + CNT_W'(k1);
        zeros_upd   = zeros_reg + CNT_W'(k0);
        r1_upd      = hit1 ? RES_W'(k1 - need1) : RES_W'(32'(r1_reg) + 32'(k1));
        r0_upd      = hit0 ? RES_W'(k0 - need0) : RES_W'(32'(r0_reg) + 32'(k0));
        slot1_upd   = hit1 ? slot1_reg + IW'(1) : slot1_reg;
        slot0_upd   = hit0 ? slot0_reg + IW'(1) : slot0_reg;
        after       = {1'b0, bi_upd} + (IW+1)'(1);

        // cumulative counts: head ones go to the current sub-block onward,
        // tail ones to the next sub-block onward, or restart a new block
        for (int j = 0; j < rsib_pkg::N_CUM; j++)
        begin
            if (blk_cross)
            begin
                cum_upd[j] = rsib_pkg::SUB_CNT_W'(kb);
            end
            else
            begin
                cum_upd[j] = cum_reg[j]
                    + ((3'(j) >= sub_reg) ? rsib_pkg::SUB_CNT_W'(ka) : '0)
                    + ((sub_cross && (3'(j) > sub_reg)) ? rsib_pkg::SUB_CNT_W'(kb) : '0);
            end
        end
    end

    // ---------------- result list assembly ----------------
    always_comb
    begin
        e_ones       = '0;
        e_ones.kind  = rsib_pkg::KIND_ONES;
        e_ones.slot  = OW'(slot1_reg);
        e_ones.value = OW'(ones_after ? bi_upd : bi_reg);

        e_zeros       = '0;
        e_zeros.kind  = rsib_pkg::KIND_ZEROS;
        e_zeros.slot  = OW'(slot0_reg);
        e_zeros.value = OW'(zeros_after ? bi_upd : bi_reg);

        e_rank       = '0;
        e_rank.kind  = rsib_pkg::KIND_RANK;
        e_rank.slot  = OW'(bi_reg);
        e_rank.value = OW'(obb_reg);
        e_rank.rel   = rsib_pkg::pack_rel(cum_reg);

        // trailing entries at the end of the vector
        t_rank       = '0;
        t_rank.kind  = rsib_pkg::KIND_RANK;
        t_rank.slot  = OW'(bi_upd);
        t_rank.value = OW'(obb_upd);
        t_rank.rel   = rsib_pkg::pack_rel(cum_upd);

        t_total       = '0;
        t_total.kind  = rsib_pkg::KIND_TOTAL;
        t_total.slot  = OW'(after);
        t_total.value = OW'(ones_upd);

        t_s1       = '0;
        t_s1.kind  = rsib_pkg::KIND_ONES;
        t_s1.slot  = OW'(slot1_upd);
        t_s1.value = OW'(after);

        t_s0       = '0;
        t_s0.kind  = rsib_pkg::KIND_ZEROS;
        t_s0.slot  = OW'(slot0_upd);
        t_s0.value = OW'(after);
        t_s0.fin   = 1'b1;

        // place of each in-word event, by bit position
        idx_ones  = RCW'(hit0 && !ones_first) + RCW'(blk_cross && ones_after);
        idx_zeros = RCW'(hit1 && ones_first) + RCW'(blk_cross && zeros_after);
        idx_rank  = RCW'(hit1 && !ones_after) + RCW'(hit0 && !zeros_after);
        n_word    = RCW'(hit1) + RCW'(hit0) + RCW'(blk_cross);
        n_new     = in_last_reg ? n_word + RCW'(rsib_pkg::TRAIL_RESULTS) : n_word;

        for (int i = 0; i < NR; i++)
        begin
            list[i] = '0;
            if (hit1 && (idx_ones == RCW'(i)))
            begin
                list[i] = e_ones;
            end
            if (hit0 && (idx_zeros == RCW'(i)))
            begin
                list[i] = e_zeros;
            end
            if (blk_cross && (idx_rank == RCW'(i)))
            begin
                list[i] = e_rank;
            end
            if (in_last_reg)
            begin
                if (n_word == RCW'(i))
                begin
                    list[i] = t_rank;
                end
                if (n_word + RCW'(1) == RCW'(i))
                begin
                    list[i] = t_total;
                end
                if (n_word + RCW'(2) == RCW'(i))
                begin
                    list[i] = t_s1;
                end
                if (n_word + RCW'(3) == RCW'(i))
                begin
                    list[i] = t_s0;
                end
            end
        end
    end

    // ---------------- next state ----------------
    always_comb
    begin
        sub_next     = sub_reg;
        sub_off_next = sub_off_reg;
        bi_next      = bi_reg;
        obb_next     = obb_reg;
        cum_next     = cum_reg;
        ones_next    = ones_reg;
        zeros_next   = zeros_reg;
        r1_next      = r1_reg;
        r0_next      = r0_reg;
        slot1_next   = slot1_reg;
        slot0_next   = slot0_reg;
        if (proc)
        begin
            if (in_last_reg)
            begin
                // vector done: back to an empty vector
                sub_next     = '0;
                sub_off_next = '0;
                bi_next      = '0;
                obb_next     = '0;
                cum_next     = '0;
                ones_next    = '0;
                zeros_next   = '0;
                r1_next      = '0;
                r0_next      = '0;
                slot1_next   = IW'(1);
                slot0_next   = IW'(1);
            end
            else
            begin
                sub_next     = sub_upd;
                sub_off_next = sub_off_upd;
                bi_next      = bi_upd;
                obb_next     = obb_upd;
                cum_next     = cum_upd;
                ones_next    = ones_upd;
                zeros_next   = zeros_upd;
                r1_next      = r1_upd;
                r0_next      = r0_upd;
                slot1_next   = slot1_upd;
                slot0_next   = slot0_upd;
            end
        end
    end

    always_comb
    begin
        res_cnt_next = res_cnt_reg;
        for (int i = 0; i < NR; i++)
        begin
            res_next[i] = res_reg[i];
        end
        if (proc)
        begin
            res_cnt_next = n_new;
            for (int i = 0; i < NR; i++)
            begin
                res_next[i] = list[i];
            end
        end
        else if (pop)
        begin
            res_cnt_next = res_cnt_reg - RCW'(1);
            for (int i = 0; i < NR - 1; i++)
            begin
                res_next[i] = res_reg[i + 1];
            end
            res_next[NR - 1] = '0;
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            sub_reg      <= '0;
            sub_off_reg  <= '0;
            bi_reg       <= '0;
            obb_reg      <= '0;
            cum_reg      <= '0;
            ones_reg     <= '0;
            zeros_reg    <= '0;
            r1_reg       <= '0;
            r0_reg       <= '0;
            slot1_reg    <= IW'(1);
            slot0_reg    <= IW'(1);
            res_cnt_reg  <= '0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            sub_reg      <= sub_next;
            sub_off_reg  <= sub_off_next;
            bi_reg       <= bi_next;
            obb_reg      <= obb_next;
            cum_reg      <= cum_next;
            ones_reg     <= ones_next;
            zeros_reg    <= zeros_next;
            r1_reg       <= r1_next;
            r0_reg       <= r0_next;
            slot1_reg    <= slot1_next;
            slot0_reg    <= slot0_next;
            res_cnt_reg  <= res_cnt_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            in_word_reg <= s_axis_tdata[rsib_pkg::WORD_BITS-1:0];
            in_cnt_reg  <= s_axis_tdata[rsib_pkg::WORD_BITS +: CW];
            in_last_reg <= s_axis_tlast;
        end
        for (int i = 0; i < NR; i++)
        begin
            res_reg[i] <= res_next[i];
        end
    end

    // ---------------- output word ----------------
    assign m_axis_tdata = {{(rsib_pkg::M_TDATA_W - rsib_pkg::M_TDATA_USED){1'b0}},
                           res_reg[0].rel, res_reg[0].value, res_reg[0].slot};
    assign m_axis_tuser = res_reg[0].kind;
    assign m_axis_tlast = res_reg[0].fin;

    // ---------------- assertions ----------------
    a_list_bound: assert property (@(posedge clk) disable iff (!rst_n)
        res_cnt_reg <= RCW'(NR))
        else $error("result list count out of range");

    a_last_is_tail: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (res_cnt_reg == RCW'(1)))
        else $error("final result is not the tail of the list");

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (proc && in_last_reg) |=> ((bi_reg == '0) && (ones_reg == '0) && (slot1_reg == IW'(1))))
        else $error("state not restarted after the last word");

    a_sub_range: assert property (@(posedge clk) disable iff (!rst_n)
        (sub_reg <= rsib_pkg::LAST_SUB) && (32'(sub_off_reg) < SUB_BLOCK_BITS))
        else $error("sub-block position out of range");

endmodule

`default_nettype wire
